>>> rtl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 3;
    localparam int PHASE_W   = 2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OFF    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INIT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONN_A = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONN_B = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOFIX  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OPER   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HB_ON_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HB_OFF_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_ON_TIME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_GAP_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_PAUSE_TIME = 3'd6;

    localparam logic [CFG_W-1:0] RST_FAST_INTERVAL  = 16'd200;
    localparam logic [CFG_W-1:0] RST_ERROR_INTERVAL = 16'd100;
    localparam logic [CFG_W-1:0] RST_HB_ON_TIME     = 16'd80;
    localparam logic [CFG_W-1:0] RST_HB_OFF_TIME    = 16'd1920;
    localparam logic [CFG_W-1:0] RST_DBL_ON_TIME    = 16'd200;
    localparam logic [CFG_W-1:0] RST_DBL_GAP_TIME   = 16'd200;
    localparam logic [CFG_W-1:0] RST_DBL_PAUSE_TIME = 16'd1000;

    localparam logic [CFG_W-1:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CFG_W-1:0] fast_interval;
        logic [CFG_W-1:0] error_interval;
        logic [CFG_W-1:0] heartbeat_on_time;
        logic [CFG_W-1:0] heartbeat_off_time;
        logic [CFG_W-1:0] double_on_time;
        logic [CFG_W-1:0] double_gap_time;
        logic [CFG_W-1:0] double_pause_time;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                pin_level;
        logic                toggle_level;
        logic [PHASE_W-1:0]  phase_count;
        logic [CFG_W-1:0]    elapsed_ticks;
    } pat_state_t;

endpackage

>>> rtl/slpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// slpg_cfg_regs
// Interval register file written through the configuration port.
// ----------------------------------------------------------------------------
module slpg_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slpg_pkg::CFG_W-1:0]     cfg_wdata,
    output slpg_pkg::cfg_t                 cfg
);

    slpg_pkg::cfg_t cfg_reg;
    slpg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                slpg_pkg::REG_FAST_INTERVAL:  cfg_next.fast_interval      = cfg_wdata;
                slpg_pkg::REG_ERROR_INTERVAL: cfg_next.error_interval     = cfg_wdata;
                slpg_pkg::REG_HB_ON_TIME:     cfg_next.heartbeat_on_time  = cfg_wdata;
                slpg_pkg::REG_HB_OFF_TIME:    cfg_next.heartbeat_off_time = cfg_wdata;
                slpg_pkg::REG_DBL_ON_TIME:    cfg_next.double_on_time     = cfg_wdata;
                slpg_pkg::REG_DBL_GAP_TIME:   cfg_next.double_gap_time    = cfg_wdata;
                slpg_pkg::REG_DBL_PAUSE_TIME: cfg_next.double_pause_time  = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_interval      <= slpg_pkg::RST_FAST_INTERVAL;
            cfg_reg.error_interval     <= slpg_pkg::RST_ERROR_INTERVAL;
            cfg_reg.heartbeat_on_time  <= slpg_pkg::RST_HB_ON_TIME;
            cfg_reg.heartbeat_off_time <= slpg_pkg::RST_HB_OFF_TIME;
            cfg_reg.double_on_time     <= slpg_pkg::RST_DBL_ON_TIME;
            cfg_reg.double_gap_time    <= slpg_pkg::RST_DBL_GAP_TIME;
            cfg_reg.double_pause_time  <= slpg_pkg::RST_DBL_PAUSE_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/slpg_pattern.sv
// ----------------------------------------------------------------------------
// slpg_pattern
// Pattern state and its registered update for a tick or a status request.
// ----------------------------------------------------------------------------
module slpg_pattern
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          opcode,
    input  logic [slpg_pkg::STATUS_W-1:0] new_status,
    input  slpg_pkg::cfg_t                cfg,
    output logic                          led_next,
    output logic [slpg_pkg::STATUS_W-1:0] status_next
);

    slpg_pkg::pat_state_t st_reg;
    slpg_pkg::pat_state_t st_next;

    logic [slpg_pkg::CFG_W-1:0] elapsed_inc;
    logic [slpg_pkg::CFG_W-1:0] interval;
    logic                       timed;
    logic                       done;

    always_comb
    begin
        elapsed_inc = (st_reg.elapsed_ticks == slpg_pkg::ELAPSED_MAX) ?
                      st_reg.elapsed_ticks : st_reg.elapsed_ticks + 16'd1;
        timed    = 1'b1;
        interval = cfg.fast_interval;
        case (st_reg.status)
            slpg_pkg::ST_CONN_A, slpg_pkg::ST_CONN_B: interval = cfg.fast_interval;
            slpg_pkg::ST_ERROR: interval = cfg.error_interval;
            slpg_pkg::ST_OPER:
            begin
                interval = st_reg.toggle_level ? cfg.heartbeat_on_time
                                               : cfg.heartbeat_off_time;
            end
            slpg_pkg::ST_NOFIX:
            begin
                case (st_reg.phase_count)
                    2'd1:    interval = cfg.double_gap_time;
                    2'd3:    interval = cfg.double_pause_time;
                    default: interval = cfg.double_on_time;
                endcase
            end
            default: timed = 1'b0;
        endcase
        done = timed && (elapsed_inc >= interval);

        st_next = st_reg;
        if (opcode == slpg_pkg::OP_STATUS)
        begin
            if (new_status != st_reg.status)
            begin
                st_next.status        = new_status;
                st_next.elapsed_ticks = '0;
                st_next.phase_count   = '0;
                st_next.toggle_level  = 1'b0;
                st_next.pin_level     = (new_status == slpg_pkg::ST_INIT);
            end
        end
        else
        begin
            st_next.elapsed_ticks = done ? '0 : elapsed_inc;
            if (st_reg.status == slpg_pkg::ST_NOFIX)
            begin
                st_next.pin_level    = ~st_reg.phase_count[0];
                st_next.toggle_level = ~st_reg.phase_count[0];
                if (done)
                begin
                    st_next.phase_count = st_reg.phase_count + 2'd1;
                end
            end
            else if (done)
            begin
                st_next.toggle_level = ~st_reg.toggle_level;
                st_next.pin_level    = ~st_reg.toggle_level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (enable)
        begin
            st_reg <= st_next;
        end
    end

    assign led_next    = st_next.pin_level;
    assign status_next = st_next.status;

endmodule

>>> rtl/status_led_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// status_led_pattern_generator_unit
// Status LED pattern generator with stream input and output channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request per item. s_tuser[0] is the opcode
//   (0 one-millisecond tick, 1 status change); s_tdata[2:0] is the status.
//   Output channel m_*: one result per request, m_tdata[0] the LED level
//   and m_tdata[3:1] the status in force after that request.
//   Configuration: cfg_we, cfg_index, cfg_wdata write the seven interval
//   registers; indexes beyond the list are ignored. Write only while idle.
//   Path: an accepted request is held in the input register, then the
//   pattern update writes its result into the result register.
//   Throughput: one request per cycle unless stalled; the pattern
//   update is a single 16-bit increment and compare on the state registers.
//   Reset: status off, LED off, counters cleared, intervals at defaults.
//   Stall: a held result blocks the update stage; one more request is
//   parked in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [2:0] new_status
    input  logic [0:0]                     s_tuser,   // [0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] led_on, [3:1] active_status
    input  logic                           cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slpg_pkg::CFG_W-1:0]     cfg_wdata
);

    slpg_pkg::cfg_t cfg;

    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [slpg_pkg::STATUS_W-1:0] in_status_reg;
    logic                          out_valid_reg;
    logic                          out_led_reg;
    logic [slpg_pkg::STATUS_W-1:0] out_status_reg;
    logic                          advance;
    logic                          led_next;
    logic [slpg_pkg::STATUS_W-1:0] status_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    slpg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slpg_pattern u_pattern
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (advance),
        .opcode      (in_op_reg),
        .new_status  (in_status_reg),
        .cfg         (cfg),
        .led_next    (led_next),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= s_tuser[0];
            in_status_reg <= s_tdata[slpg_pkg::STATUS_W-1:0];
        end
        if (advance)
        begin
            out_led_reg    <= led_next;
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg, out_led_reg};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

    a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("update did not produce a result");

    a_status_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == slpg_pkg::OP_STATUS)
        |=> out_status_reg == $past(in_status_reg))
        else $error("status request not applied");

    a_init_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == slpg_pkg::ST_INIT) |=> out_led_reg)
        else $error("LED dark in init status");
`endif

endmodule
